// ----- rtl/owmc_pkg.sv -----
// Shared types, constants and helpers for the one-wire bus master core.
// No dependencies; every other file imports this package.
package owmc_pkg;

    // Width of the slot timing counter (legal range 9 to 16).
    localparam int CNT_W = 12;
    localparam int REG_W = 12;
    localparam int WIDE_W = (CNT_W > REG_W) ? CNT_W : REG_W;
    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    localparam int NUM_REGS = 8;
    localparam int IDX_W = 3;
    localparam int ADDR_W = IDX_W + 2;
    localparam int DATA_W = 32;

    // Register indexes.
    localparam logic [IDX_W-1:0] REG_RESET_LOW     = 3'd0;
    localparam logic [IDX_W-1:0] REG_PRESENCE_WAIT = 3'd1;
    localparam logic [IDX_W-1:0] REG_PRESENCE_TAIL = 3'd2;
    localparam logic [IDX_W-1:0] REG_WRITE_LOW     = 3'd3;
    localparam logic [IDX_W-1:0] REG_WRITE_HOLD    = 3'd4;
    localparam logic [IDX_W-1:0] REG_READ_LOW      = 3'd5;
    localparam logic [IDX_W-1:0] REG_READ_SAMPLE   = 3'd6;
    localparam logic [IDX_W-1:0] REG_READ_TAIL     = 3'd7;

    // Command function codes.
    localparam logic [1:0] FUNC_RESET = 2'd0;
    localparam logic [1:0] FUNC_WRITE = 2'd1;
    localparam logic [1:0] FUNC_READ  = 2'd2;

    // Command queue between front and sequencer; depth must be a power of two.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

    typedef logic [NUM_REGS-1:0][REG_W-1:0] cfg_t;

    localparam cfg_t CFG_RESET = {
        12'd38, 12'd15, 12'd2, 12'd60, 12'd3, 12'd420, 12'd60, 12'd480
    };

    typedef struct packed {
        logic       cmd_valid;
        logic [1:0] func;
        logic [7:0] cmd_byte;
        logic       line_level;
    } in_t;

    typedef struct packed {
        logic       drive_low;
        logic       busy_res;
        logic       done_res;
        logic [7:0] read_byte;
        logic       presence;
    } out_t;

    // A tick after classification: at most one of the start flags is set.
    typedef struct packed {
        logic       start_reset;
        logic       start_write;
        logic       start_read;
        logic [7:0] data;
        logic       level;
    } cmd_t;

    typedef enum logic [8:0] {
        PH_IDLE     = 9'b000000001,
        PH_RST_LOW  = 9'b000000010,
        PH_RST_WAIT = 9'b000000100,
        PH_RST_TAIL = 9'b000001000,
        PH_WR_LOW   = 9'b000010000,
        PH_WR_HOLD  = 9'b000100000,
        PH_RD_LOW   = 9'b001000000,
        PH_RD_WAIT  = 9'b010000000,
        PH_RD_TAIL  = 9'b100000000
    } phase_t;

    // Saturates a register value to the counter range.
    function automatic logic [CNT_W-1:0] clip_len(input logic [REG_W-1:0] r);
        logic [WIDE_W-1:0] w;
        w = WIDE_W'(r);
        if (w > WIDE_W'(CNT_MAX)) begin
            w = WIDE_W'(CNT_MAX);
        end
        return CNT_W'(w);
    endfunction

endpackage

// ----- rtl/owmc_regs.sv -----
// Timing register bank behind an APB-style port.
// Depends on owmc_pkg.
module owmc_regs (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [owmc_pkg::ADDR_W-1:0]  paddr,
    input  logic [owmc_pkg::DATA_W-1:0]  pwdata,
    output logic [owmc_pkg::DATA_W-1:0]  prdata,
    output logic                         pready,
    output owmc_pkg::cfg_t               cfg
);
    import owmc_pkg::*;

    cfg_t             regs_reg;
    cfg_t             regs_next;
    logic [IDX_W-1:0] idx;

    assign idx    = paddr[ADDR_W-1:2];
    assign pready = 1'b1;
    assign prdata = DATA_W'(regs_reg[idx]);
    assign cfg    = regs_reg;

    always_comb begin
        regs_next = regs_reg;
        if (psel && penable && pwrite && pready) begin
            regs_next[idx] = pwdata[REG_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            regs_reg <= CFG_RESET;
        end else begin
            regs_reg <= regs_next;
        end
    end

endmodule

// ----- rtl/owmc_front.sv -----
// Input side: takes tick beats, classifies the command they carry and
// queues them for the sequencer. Depends on owmc_pkg.
module owmc_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  owmc_pkg::in_t       s_data,
    output logic                q_valid,
    output owmc_pkg::cmd_t      q_item,
    input  logic                q_pop
);
    import owmc_pkg::*;

    cmd_t              mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;
    cmd_t              item;
    logic              push;
    logic              pop;

    // Function code 3 means nothing and is dropped here.
    always_comb begin
        item             = '0;
        item.data        = s_data.cmd_byte;
        item.level       = s_data.line_level;
        item.start_reset = s_data.cmd_valid && (s_data.func == FUNC_RESET);
        item.start_write = s_data.cmd_valid && (s_data.func == FUNC_WRITE);
        item.start_read  = s_data.cmd_valid && (s_data.func == FUNC_READ);
    end

    assign s_ready = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign q_valid = (count_reg != '0);
    assign q_item  = mem_reg[rd_ptr_reg];
    assign push    = s_valid && s_ready;
    assign pop     = q_pop && q_valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= QCNT_W'(QUEUE_DEPTH))
        else $error("command queue count beyond its depth");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg == '0) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("empty queue with pointers apart");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (push && !pop) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("queue count missed a write");

endmodule

// ----- rtl/owmc_seq.sv -----
// Slot sequencer: steps the bus phase machine once per queued tick and
// holds each result in an output register. Depends on owmc_pkg.
module owmc_seq (
    input  logic                aclk,
    input  logic                aresetn,
    input  owmc_pkg::cfg_t      cfg,
    input  logic                q_valid,
    input  owmc_pkg::cmd_t      q_item,
    output logic                q_pop,
    output logic                m_valid,
    input  logic                m_ready,
    output owmc_pkg::out_t      m_data
);
    import owmc_pkg::*;

    phase_t           phase_reg;
    phase_t           phase_next;
    logic [CNT_W-1:0] tick_count_reg;
    logic [CNT_W-1:0] tick_count_next;
    logic [2:0]       bit_index_reg;
    logic [2:0]       bit_index_next;
    logic [7:0]       shift_byte_reg;
    logic [7:0]       shift_byte_next;
    logic             presence_reg;
    logic             presence_next;
    logic [7:0]       result_byte_reg;
    logic [7:0]       result_byte_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    out_t             out_reg;
    out_t             out_next;

    logic [CNT_W-1:0] cur_len;
    logic [CNT_W:0]   tick_inc;
    logic             phase_end;
    logic             done;
    logic             last_bit;
    logic [7:0]       sampled;

    assign q_pop    = q_valid && (!out_valid_reg || m_ready);
    assign m_valid  = out_valid_reg;
    assign m_data   = out_reg;
    assign last_bit = (bit_index_reg == 3'd7);
    assign sampled  = {q_item.level, shift_byte_reg[7:1]};

    always_comb begin
        case (phase_reg)
            PH_RST_LOW:  cur_len = clip_len(cfg[REG_RESET_LOW]);
            PH_RST_WAIT: cur_len = clip_len(cfg[REG_PRESENCE_WAIT]);
            PH_RST_TAIL: cur_len = clip_len(cfg[REG_PRESENCE_TAIL]);
            PH_WR_LOW:   cur_len = clip_len(cfg[REG_WRITE_LOW]);
            PH_WR_HOLD:  cur_len = clip_len(cfg[REG_WRITE_HOLD]);
            PH_RD_LOW:   cur_len = clip_len(cfg[REG_READ_LOW]);
            PH_RD_WAIT:  cur_len = clip_len(cfg[REG_READ_SAMPLE]);
            PH_RD_TAIL:  cur_len = clip_len(cfg[REG_READ_TAIL]);
            default:     cur_len = CNT_W'(1);
        endcase
    end

    // A length of zero ends the phase after one tick, as a length of one does.
    assign tick_inc  = (CNT_W+1)'(tick_count_reg) + (CNT_W+1)'(1);
    assign phase_end = (tick_inc >= {1'b0, cur_len});

    always_comb begin
        phase_next       = phase_reg;
        tick_count_next  = tick_count_reg;
        bit_index_next   = bit_index_reg;
        shift_byte_next  = shift_byte_reg;
        presence_next    = presence_reg;
        result_byte_next = result_byte_reg;
        done             = 1'b0;

        if (phase_reg == PH_IDLE) begin
            if (q_item.start_reset) begin
                phase_next      = PH_RST_LOW;
                bit_index_next  = '0;
                tick_count_next = '0;
            end else if (q_item.start_write) begin
                phase_next      = PH_WR_LOW;
                shift_byte_next = q_item.data;
                bit_index_next  = '0;
                tick_count_next = '0;
            end else if (q_item.start_read) begin
                phase_next      = PH_RD_LOW;
                shift_byte_next = '0;
                bit_index_next  = '0;
                tick_count_next = '0;
            end
        end else if (!phase_end) begin
            tick_count_next = tick_inc[CNT_W-1:0];
        end else begin
            tick_count_next = '0;
            case (phase_reg)
                PH_RST_LOW: begin
                    phase_next = PH_RST_WAIT;
                end
                PH_RST_WAIT: begin
                    presence_next = !q_item.level;
                    // The tail is only waited out when a device answered.
                    if (!q_item.level && (clip_len(cfg[REG_PRESENCE_TAIL]) != '0)) begin
                        phase_next = PH_RST_TAIL;
                    end else begin
                        phase_next = PH_IDLE;
                        done       = 1'b1;
                    end
                end
                PH_WR_LOW: begin
                    phase_next = PH_WR_HOLD;
                end
                PH_WR_HOLD: begin
                    shift_byte_next = {1'b0, shift_byte_reg[7:1]};
                    bit_index_next  = bit_index_reg + 1'b1;
                    phase_next      = last_bit ? PH_IDLE : PH_WR_LOW;
                    done            = last_bit;
                end
                PH_RD_LOW: begin
                    phase_next = PH_RD_WAIT;
                end
                PH_RD_WAIT: begin
                    shift_byte_next = sampled;
                    if (clip_len(cfg[REG_READ_TAIL]) != '0) begin
                        phase_next = PH_RD_TAIL;
                    end else begin
                        bit_index_next = bit_index_reg + 1'b1;
                        phase_next     = last_bit ? PH_IDLE : PH_RD_LOW;
                        done           = last_bit;
                        if (last_bit) begin
                            result_byte_next = sampled;
                        end
                    end
                end
                PH_RD_TAIL: begin
                    bit_index_next = bit_index_reg + 1'b1;
                    phase_next     = last_bit ? PH_IDLE : PH_RD_LOW;
                    done           = last_bit;
                    if (last_bit) begin
                        result_byte_next = shift_byte_reg;
                    end
                end
                default: begin
                    phase_next = PH_IDLE;
                    done       = 1'b1;
                end
            endcase
        end
    end

    always_comb begin
        out_next = out_reg;
        if (q_pop) begin
            case (phase_next)
                PH_RST_LOW, PH_WR_LOW, PH_RD_LOW: out_next.drive_low = 1'b1;
                PH_WR_HOLD: out_next.drive_low = !shift_byte_next[0];
                default:    out_next.drive_low = 1'b0;
            endcase
            out_next.busy_res  = (phase_next != PH_IDLE);
            out_next.done_res  = done;
            out_next.read_byte = result_byte_next;
            out_next.presence  = presence_next;
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (q_pop) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        out_reg <= out_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg       <= PH_IDLE;
            tick_count_reg  <= '0;
            bit_index_reg   <= '0;
            shift_byte_reg  <= '0;
            presence_reg    <= 1'b0;
            result_byte_reg <= '0;
            out_valid_reg   <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
            if (q_pop) begin
                phase_reg       <= phase_next;
                tick_count_reg  <= tick_count_next;
                bit_index_reg   <= bit_index_next;
                shift_byte_reg  <= shift_byte_next;
                presence_reg    <= presence_next;
                result_byte_reg <= result_byte_next;
            end
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_reg.done_res) |-> (!out_reg.busy_res && !out_reg.drive_low))
        else $error("done beat shows the bus still in use");

    assert property (@(posedge aclk) disable iff (!aresetn)
        !q_pop |=> $stable(phase_reg) && $stable(tick_count_reg))
        else $error("sequencer moved without a tick");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_IDLE) |-> (tick_count_reg == '0))
        else $error("tick counter left running in idle");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg != PH_IDLE && cur_len != '0) |-> (tick_count_reg < cur_len))
        else $error("tick counter past the phase length");

endmodule

// ----- rtl/one_wire_bus_master_core.sv -----
// One-wire bus master: takes one tick beat per clock and returns one result
// beat per tick while the result side is ready. That sustained rate of one
// beat per clock is held by the sequencer, which does a whole tick step
// combinationally; each beat passes through the two-entry command queue and
// then the output register, where it waits while the result side is not ready.
// Timing registers must be written over the APB port between commands; the
// block itself does not enforce this. Depends on owmc_pkg, owmc_regs,
// owmc_front and owmc_seq.
module one_wire_bus_master_core (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [owmc_pkg::ADDR_W-1:0]  paddr,
    input  logic [owmc_pkg::DATA_W-1:0]  pwdata,
    output logic [owmc_pkg::DATA_W-1:0]  prdata,
    output logic                         pready,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  owmc_pkg::in_t                s_data,
    output logic                         m_valid,
    input  logic                         m_ready,
    output owmc_pkg::out_t               m_data
);
    import owmc_pkg::*;

    cfg_t cfg;
    logic q_valid;
    cmd_t q_item;
    logic q_pop;

    owmc_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    owmc_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .q_valid (q_valid),
        .q_item  (q_item),
        .q_pop   (q_pop)
    );

    owmc_seq u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg),
        .q_valid (q_valid),
        .q_item  (q_item),
        .q_pop   (q_pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

// ----- bench/testbench.sv -----
// Self-checking bench for one_wire_bus_master_core: tick beats in, bus outputs out.
// Predicts each result beat, or takes it from a script, in step with the input and programs timings over APB.
// Depends on owmc_pkg and the RTL of the core.
module testbench;
    import owmc_pkg::*;

    // Function code that the master must ignore.
    localparam logic [1:0] FUNC_NONE = 2'd3;
    localparam int PRESSURE_CYCLES = 250;
    localparam int STALL_LIMIT = 2000;
    localparam int DRAIN_CYCLES = 8;

    typedef struct packed {
        in_t  stim;
        logic typed;
        out_t want;
        logic drain;
    } script_row_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [DATA_W-1:0] pwdata = '0;
    logic [DATA_W-1:0] prdata;
    logic pready;
    logic s_valid = 1'b0;
    logic s_ready;
    in_t s_data = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    out_t m_data;

    // Shadow of the timing registers and of the master's sequencer.
    logic [REG_W-1:0] timing [NUM_REGS];
    int plan [NUM_REGS];
    phase_t seq_phase = PH_IDLE;
    int slot_ticks = 0;
    int bit_pos = 0;
    logic [7:0] shifter = '0;
    logic presence_seen = 1'b0;
    logic [7:0] last_read = '0;

    out_t bus_outputs_due [$];
    int errors = 0;
    int results_seen = 0;
    int stalled_cycles = 0;
    bit calm = 1'b0;
    bit hold_off_req = 1'b0;

    // Bit fields of want: drive_low, busy, done, then read byte, then presence.
    script_row_t opening [11] = '{
        '{ {1'b0, FUNC_READ,  8'hFF, 1'b1}, 1'b1, {3'b000, 8'h00, 1'b0}, 1'b0 },
        '{ {1'b1, FUNC_NONE,  8'h00, 1'b0}, 1'b1, {3'b000, 8'h00, 1'b0}, 1'b0 },
        '{ {1'b0, FUNC_WRITE, 8'h5A, 1'b0}, 1'b1, {3'b000, 8'h00, 1'b0}, 1'b0 },
        // A device answers; the commands on the busy tick and the done tick are dropped.
        '{ {1'b1, FUNC_RESET, 8'h00, 1'b1}, 1'b1, {3'b110, 8'h00, 1'b0}, 1'b0 },
        '{ {1'b1, FUNC_WRITE, 8'hFF, 1'b1}, 1'b1, {3'b010, 8'h00, 1'b0}, 1'b0 },
        '{ {1'b1, FUNC_READ,  8'h00, 1'b0}, 1'b1, {3'b001, 8'h00, 1'b1}, 1'b0 },
        '{ {1'b0, FUNC_RESET, 8'h00, 1'b1}, 1'b1, {3'b000, 8'h00, 1'b1}, 1'b0 },
        // No device on the bus, so the reset ends on its sample tick.
        '{ {1'b1, FUNC_RESET, 8'h81, 1'b0}, 1'b1, {3'b110, 8'h00, 1'b1}, 1'b0 },
        '{ {1'b0, FUNC_READ,  8'h7E, 1'b0}, 1'b1, {3'b010, 8'h00, 1'b1}, 1'b0 },
        '{ {1'b0, FUNC_NONE,  8'h3C, 1'b1}, 1'b1, {3'b001, 8'h00, 1'b0}, 1'b0 },
        '{ {1'b1, FUNC_WRITE, 8'hFF, 1'b1}, 1'b0, '0, 1'b1 }
    };

    one_wire_bus_master_core dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    initial begin
        forever #6 aclk = ~aclk;
    end

    task automatic note_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
        $display("mismatch at result %0d: %s got 0x%0h, expected 0x%0h",
                 results_seen, what, got, want);
        errors++;
    endtask

    function automatic int pick_gap();
        int roll;
        if (calm) return 0;
        roll = $urandom_range(0, 99);
        if (roll < 70) return 0;
        if (roll < 95) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Register value saturated to the counter range.
    function automatic int clipped(input int idx);
        int v;
        v = int'(timing[idx]);
        if (v > int'(CNT_MAX)) v = int'(CNT_MAX);
        return v;
    endfunction

    function automatic int span_of(input phase_t p);
        int v;
        case (p)
            PH_RST_LOW:  v = clipped(REG_RESET_LOW);
            PH_RST_WAIT: v = clipped(REG_PRESENCE_WAIT);
            PH_RST_TAIL: v = clipped(REG_PRESENCE_TAIL);
            PH_WR_LOW:   v = clipped(REG_WRITE_LOW);
            PH_WR_HOLD:  v = clipped(REG_WRITE_HOLD);
            PH_RD_LOW:   v = clipped(REG_READ_LOW);
            PH_RD_WAIT:  v = clipped(REG_READ_SAMPLE);
            PH_RD_TAIL:  v = clipped(REG_READ_TAIL);
            default:     v = 1;
        endcase
        return (v == 0) ? 1 : v;
    endfunction

    function automatic bit close_slot(input phase_t next_slot);
        bit_pos = (bit_pos + 1) % 8;
        if (bit_pos == 0) begin
            seq_phase = PH_IDLE;
            return 1'b1;
        end
        seq_phase = next_slot;
        return 1'b0;
    endfunction

    // Advances the shadow sequencer by one tick and returns the bus outputs for it.
    function automatic out_t master_tick(input in_t t);
        out_t r;
        bit done;
        int next_count;
        done = 1'b0;
        if (seq_phase == PH_IDLE) begin
            if (t.cmd_valid) begin
                bit_pos = 0;
                slot_ticks = 0;
                case (t.func)
                    FUNC_RESET: seq_phase = PH_RST_LOW;
                    FUNC_WRITE: begin
                        shifter = t.cmd_byte;
                        seq_phase = PH_WR_LOW;
                    end
                    FUNC_READ: begin
                        shifter = '0;
                        seq_phase = PH_RD_LOW;
                    end
                    default: ;
                endcase
            end
        end else begin
            next_count = slot_ticks + 1;
            if (next_count < span_of(seq_phase)) begin
                slot_ticks = next_count;
            end else begin
                slot_ticks = 0;
                case (seq_phase)
                    PH_RST_LOW: seq_phase = PH_RST_WAIT;
                    PH_RST_WAIT: begin
                        presence_seen = !t.line_level;
                        if (presence_seen && clipped(REG_PRESENCE_TAIL) != 0) begin
                            seq_phase = PH_RST_TAIL;
                        end else begin
                            seq_phase = PH_IDLE;
                            done = 1'b1;
                        end
                    end
                    PH_WR_LOW: seq_phase = PH_WR_HOLD;
                    PH_WR_HOLD: begin
                        shifter = shifter >> 1;
                        done = close_slot(PH_WR_LOW);
                    end
                    PH_RD_LOW: seq_phase = PH_RD_WAIT;
                    PH_RD_WAIT: begin
                        // Read bits come in at the top, so the first one ends in bit 0.
                        shifter = {t.line_level, shifter[7:1]};
                        if (clipped(REG_READ_TAIL) != 0) begin
                            seq_phase = PH_RD_TAIL;
                        end else begin
                            done = close_slot(PH_RD_LOW);
                            if (done) last_read = shifter;
                        end
                    end
                    PH_RD_TAIL: begin
                        done = close_slot(PH_RD_LOW);
                        if (done) last_read = shifter;
                    end
                    default: begin
                        seq_phase = PH_IDLE;
                        done = 1'b1;
                    end
                endcase
            end
        end
        case (seq_phase)
            PH_RST_LOW, PH_WR_LOW, PH_RD_LOW: r.drive_low = 1'b1;
            PH_WR_HOLD: r.drive_low = !shifter[0];
            default: r.drive_low = 1'b0;
        endcase
        r.busy_res = (seq_phase != PH_IDLE);
        r.done_res = done;
        r.read_byte = last_read;
        r.presence = presence_seen;
        return r;
    endfunction

    // Mostly well-formed commands when idle; occasional stray commands while busy.
    function automatic in_t random_tick();
        in_t t;
        t.cmd_byte = 8'($urandom);
        t.line_level = 1'($urandom);
        t.func = 2'($urandom);
        t.cmd_valid = 1'b0;
        if (seq_phase == PH_IDLE) begin
            case ($urandom_range(0, 9))
                0: ;
                1: begin
                    t.cmd_valid = 1'b1;
                    t.func = FUNC_NONE;
                end
                default: begin
                    t.cmd_valid = 1'b1;
                    t.func = 2'($urandom_range(FUNC_RESET, FUNC_READ));
                end
            endcase
        end else begin
            t.cmd_valid = ($urandom_range(0, 7) == 0);
        end
        return t;
    endfunction

    task automatic send_tick(input in_t t, input bit typed, input out_t want);
        int gap;
        out_t pred;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= t;
        do @(posedge aclk); while (!s_ready);
        pred = master_tick(t);
        bus_outputs_due.push_back(typed ? want : pred);
    endtask

    task automatic finish_command();
        while (seq_phase != PH_IDLE) send_tick(random_tick(), 1'b0, '0);
    endtask

    task automatic issue_command(input logic [1:0] f);
        in_t t;
        t = random_tick();
        t.cmd_valid = 1'b1;
        t.func = f;
        send_tick(t, 1'b0, '0);
        finish_command();
    endtask

    task automatic run_traffic(input int ticks, input bit squeeze);
        for (int n = 0; n < ticks; n++) begin
            if (squeeze && n == ticks / 3) hold_off_req = 1'b1;
            send_tick(random_tick(), 1'b0, '0);
        end
    endtask

    // One APB transfer; the caller lowers psel and penable after the last one.
    task automatic apb_xfer(input logic wr, input int idx, input logic [DATA_W-1:0] wdata,
                            output logic [DATA_W-1:0] rdata);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= wr;
        paddr <= ADDR_W'(idx * 4);
        pwdata <= wdata;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        rdata = prdata;
    endtask

    // Called with the master idle: checks each register, writes it and reads it back.
    task automatic apply_plan();
        logic [DATA_W-1:0] back;
        s_valid <= 1'b0;
        while (bus_outputs_due.size() != 0) @(posedge aclk);
        for (int i = 0; i < NUM_REGS; i++) begin
            apb_xfer(1'b0, i, '0, back);
            if (back !== DATA_W'(timing[i]))
                note_mismatch("register value", back, DATA_W'(timing[i]));
            apb_xfer(1'b1, i, DATA_W'(plan[i]), back);
            apb_xfer(1'b0, i, '0, back);
            if (back !== DATA_W'(plan[i])) note_mismatch("register readback", back, plan[i]);
            timing[i] = REG_W'(plan[i]);
        end
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    initial begin : result_sink
        int stall_left;
        stall_left = 0;
        forever begin
            @(posedge aclk);
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                stall_left = PRESSURE_CYCLES;
            end else if (stall_left == 0 && $urandom_range(0, 3) == 0) begin
                stall_left = pick_gap();
            end
            if (stall_left > 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        out_t want;
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (bus_outputs_due.size() == 0) begin
                note_mismatch("result beat with nothing pending", 32'(m_data), '0);
            end else begin
                want = bus_outputs_due.pop_front();
                if (m_data.drive_low !== want.drive_low)
                    note_mismatch("drive_low", 32'(m_data.drive_low), 32'(want.drive_low));
                if (m_data.busy_res !== want.busy_res)
                    note_mismatch("busy_res", 32'(m_data.busy_res), 32'(want.busy_res));
                if (m_data.done_res !== want.done_res)
                    note_mismatch("done_res", 32'(m_data.done_res), 32'(want.done_res));
                if (m_data.read_byte !== want.read_byte)
                    note_mismatch("read_byte", 32'(m_data.read_byte), 32'(want.read_byte));
                if (m_data.presence !== want.presence)
                    note_mismatch("presence", 32'(m_data.presence), 32'(want.presence));
            end
        end
    end

    // Ends a hung run: counts cycles in which no beat and no register access moves.
    always @(posedge aclk) begin
        if (!aresetn || psel || (s_valid && s_ready) || (m_valid && m_ready)) begin
            stalled_cycles = 0;
        end else begin
            stalled_cycles++;
            if (stalled_cycles >= STALL_LIMIT) begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    initial begin : stimulus
        for (int i = 0; i < NUM_REGS; i++) timing[i] = CFG_RESET[i];
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Shortest timings: zero lengths act as one tick and zero tails are skipped.
        for (int i = 0; i < NUM_REGS; i++) plan[i] = 0;
        apply_plan();
        foreach (opening[k]) begin
            send_tick(opening[k].stim, opening[k].typed, opening[k].want);
            if (opening[k].drain) finish_command();
        end
        run_traffic(350, 1'b1);

        finish_command();
        for (int i = 0; i < NUM_REGS; i++) plan[i] = 1;
        apply_plan();
        calm = 1'b1;
        run_traffic(200, 1'b0);
        calm = 1'b0;

        repeat (3) begin
            finish_command();
            for (int i = 0; i < NUM_REGS; i++) plan[i] = $urandom_range(0, 6);
            apply_plan();
            run_traffic(300, 1'b0);
        end

        // Longest timings are written and read back; running a command at them would
        // take tens of thousands of ticks, so the last commands use short timings.
        finish_command();
        for (int i = 0; i < NUM_REGS; i++) plan[i] = int'(CNT_MAX);
        apply_plan();
        for (int i = 0; i < NUM_REGS; i++) plan[i] = $urandom_range(1, 4);
        apply_plan();
        calm = 1'b1;
        issue_command(FUNC_RESET);
        issue_command(FUNC_WRITE);
        issue_command(FUNC_READ);

        s_valid <= 1'b0;
        while (bus_outputs_due.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
